>>> rtl/ddm_pkg.sv
// Shared constants for the differential drive mixer with link-loss stop.
// No dependencies; imported by the mixer top level and the checker.
package ddm_pkg;

   // Drive and servo limits.
   localparam int FULL_SPEED = 255;
   localparam int SERVO_MAX  = 180;

   // Register reset values that do not depend on the stick width.
   localparam logic [7:0]  DEADZONE_RESET = 8'd5;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
   localparam logic [15:0] TIMER_MAX      = 16'hFFFF;

   // Register indexes on the configuration port (word address).
   localparam logic [1:0] REG_STICK_HIGH = 2'd0;
   localparam logic [1:0] REG_STICK_LOW  = 2'd1;
   localparam logic [1:0] REG_DEADZONE   = 2'd2;
   localparam logic [1:0] REG_TIMEOUT    = 2'd3;

   // Item operation codes.
   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Stick channel codes, in the order the sequencer maps them.
   localparam logic [1:0] CH_SERVO    = 2'd0;
   localparam logic [1:0] CH_TURN     = 2'd1;
   localparam logic [1:0] CH_STRAIGHT = 2'd2;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_POST = 6'b001000,
      ST_MIX  = 6'b010000,
      ST_EMIT = 6'b100000
   } seq_state_type;

endpackage

>>> rtl/differential_drive_mixer_estop.sv
// Top level of the differential drive mixer with link-loss emergency stop.
// Depends on ddm_pkg and on ddm_divider, the shared iterative divider.
//
// Each transfer on the req_ channel is either a control packet or a one
// millisecond tick, and each one yields exactly one transfer on the rsp_
// channel. A packet maps the servo, turn and straight sticks in turn through
// one shared divider that produces one quotient bit per cycle; each stick
// passes through ST_LOAD, ST_DIV and ST_POST, and the packet then goes
// through ST_MIX and ST_EMIT. A tick updates the link timer in the cycle it
// is accepted and goes straight to ST_EMIT, where its result is loaded into
// the output register once the output is free. req_stall stays high
// from the acceptance of an item until its result has been loaded into the
// output register; the output register holds a stalled result while the
// block goes back to accepting the next item. Configuration is written
// through the APB-style port, registers at byte addresses 0, 4, 8 and 12
// (stick_high, stick_low, deadzone, timeout_ms), and should only be written
// while the block is idle.
module differential_drive_mixer_estop #(
   parameter int STICK_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [STICK_BITS-1:0] req_servo_stick,
   input  logic [STICK_BITS-1:0] req_turn_stick,
   input  logic [STICK_BITS-1:0] req_straight_stick,
   input  logic                  req_enable_switch,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_left_forward_pwm,
   output logic [7:0]            rsp_left_reverse_pwm,
   output logic [7:0]            rsp_right_forward_pwm,
   output logic [7:0]            rsp_right_reverse_pwm,
   output logic [7:0]            rsp_servo_deg,
   output logic                  rsp_servo_active,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   import ddm_pkg::*;

   // Dividend holds |stick - stick_high| * 510 (180 for the servo), which
   // needs nine more bits than a stick. Signed mapped values need two more
   // bits than that, and the mixed sum one more again.
   localparam int SB = STICK_BITS;
   localparam int NW = SB + 9;
   localparam int VW = NW + 2;
   localparam int MW = VW + 1;

   localparam logic signed [MW-1:0] SPEED_HI = MW'(FULL_SPEED);
   localparam logic signed [MW-1:0] SPEED_LO = -MW'(FULL_SPEED);

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [SB-1:0] stick_high_ff;
   logic [SB-1:0] stick_low_ff;
   logic [7:0]    deadzone_ff;
   logic [15:0]   timeout_ff;
   logic          cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_high_ff <= '1;
         stick_low_ff  <= '0;
         deadzone_ff   <= DEADZONE_RESET;
         timeout_ff    <= TIMEOUT_RESET;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_STICK_HIGH: stick_high_ff <= pwdata[SB-1:0];
            REG_STICK_LOW:  stick_low_ff  <= pwdata[SB-1:0];
            REG_DEADZONE:   deadzone_ff   <= pwdata[7:0];
            REG_TIMEOUT:    timeout_ff    <= pwdata[15:0];
            default:        timeout_ff    <= timeout_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_STICK_HIGH: prdata = 32'(stick_high_ff);
         REG_STICK_LOW:  prdata = 32'(stick_low_ff);
         REG_DEADZONE:   prdata = 32'(deadzone_ff);
         REG_TIMEOUT:    prdata = 32'(timeout_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer and block state.
   // ---------------------------------------------------------------------
   seq_state_type state_ff, state_in;

   logic [1:0]           chan_ff, chan_in;
   logic [15:0]          link_timer_ff, link_timer_in;
   logic                 drive_enabled_ff, drive_enabled_in;
   logic signed [8:0]    left_speed_ff, left_speed_in;
   logic signed [8:0]    right_speed_ff, right_speed_in;
   logic [7:0]           servo_pos_ff, servo_pos_in;

   // Latched packet fields and intermediate values.
   logic [SB-1:0]        servo_stick_ff, turn_stick_ff, straight_stick_ff;
   logic                 enable_ff;
   logic                 neg_ff, den_zero_ff;
   logic signed [VW-1:0] q_ff, q_in;
   logic signed [VW-1:0] turn_ff, straight_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_accept;
   logic                 out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Operand set-up for the selected stick: |stick - stick_high| scaled by
   // the output span, and the sign of the quotient.
   // ---------------------------------------------------------------------
   logic [SB-1:0]        stick_sel;
   logic signed [SB:0]   diff;
   logic signed [SB:0]   diff_neg;
   logic [SB-1:0]        diff_mag;
   logic signed [SB:0]   den;
   logic signed [SB:0]   den_neg;
   logic [SB-1:0]        den_mag;
   logic [8:0]           span;
   logic [NW-1:0]        num_mag;
   logic                 div_start;
   logic                 div_done;
   logic [NW-1:0]        div_quo;

   always_comb begin
      case (chan_ff)
         CH_SERVO: stick_sel = servo_stick_ff;
         CH_TURN:  stick_sel = turn_stick_ff;
         default:  stick_sel = straight_stick_ff;
      endcase
   end

   assign diff     = $signed({1'b0, stick_sel}) - $signed({1'b0, stick_high_ff});
   assign diff_neg = -diff;
   assign diff_mag = diff[SB] ? diff_neg[SB-1:0] : diff[SB-1:0];
   assign den      = $signed({1'b0, stick_low_ff}) - $signed({1'b0, stick_high_ff});
   assign den_neg  = -den;
   assign den_mag  = den[SB] ? den_neg[SB-1:0] : den[SB-1:0];
   assign span     = (chan_ff == CH_SERVO) ? 9'(SERVO_MAX) : 9'(2 * FULL_SPEED);
   assign num_mag  = NW'(diff_mag) * NW'(span);
   assign div_start = (state_ff == ST_LOAD);

   ddm_divider #(
      .NUM_BITS(NW),
      .DEN_BITS(SB)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag),
      .divisor  (den_mag),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Signed quotient plus the low end of the output range. Equal stick
   // bounds give zero outright, without the offset.
   logic signed [VW-1:0] q_ext;
   logic signed [VW-1:0] q_signed;
   logic signed [VW-1:0] q_offset;

   assign q_ext    = $signed(VW'(div_quo));
   assign q_signed = neg_ff ? -q_ext : q_ext;
   assign q_offset = (chan_ff == CH_SERVO) ? VW'(0) : VW'(FULL_SPEED);

   // Deadzone and servo saturation on the stored mapped value.
   logic signed [VW-1:0] q_neg;
   logic [VW-1:0]        q_mag;
   logic signed [VW-1:0] q_dead;
   logic [7:0]           q_servo;

   assign q_neg  = -q_ff;
   assign q_mag  = q_ff[VW-1] ? q_neg : q_ff;
   assign q_dead = (q_mag < VW'(deadzone_ff)) ? '0 : q_ff;

   always_comb begin
      if (q_ff[VW-1]) begin
         q_servo = 8'd0;
      end else if (q_ff > VW'(SERVO_MAX)) begin
         q_servo = 8'(SERVO_MAX);
      end else begin
         q_servo = q_ff[7:0];
      end
   end

   // Mixing with clamping to full speed in either direction.
   logic signed [MW-1:0] sum_left;
   logic signed [MW-1:0] sum_right;
   logic signed [8:0]    clamp_left;
   logic signed [8:0]    clamp_right;

   assign sum_left  = MW'(straight_ff) - MW'(turn_ff);
   assign sum_right = MW'(straight_ff) + MW'(turn_ff);

   always_comb begin
      if (sum_left > SPEED_HI) begin
         clamp_left = 9'(FULL_SPEED);
      end else if (sum_left < SPEED_LO) begin
         clamp_left = -9'(FULL_SPEED);
      end else begin
         clamp_left = sum_left[8:0];
      end
      if (sum_right > SPEED_HI) begin
         clamp_right = 9'(FULL_SPEED);
      end else if (sum_right < SPEED_LO) begin
         clamp_right = -9'(FULL_SPEED);
      end else begin
         clamp_right = sum_right[8:0];
      end
   end

   // A tick counts the link timer up, saturating at its top value.
   logic [15:0] timer_tick;

   assign timer_tick = (link_timer_ff != TIMER_MAX) ? link_timer_ff + 16'd1 : link_timer_ff;

   always_comb begin
      state_in         = state_ff;
      chan_in          = chan_ff;
      link_timer_in    = link_timer_ff;
      drive_enabled_in = drive_enabled_ff;
      left_speed_in    = left_speed_ff;
      right_speed_in   = right_speed_ff;
      servo_pos_in     = servo_pos_ff;
      q_in             = q_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_operation == OP_TICK) begin
                  link_timer_in = timer_tick;
                  if (timer_tick > timeout_ff) begin
                     drive_enabled_in = 1'b0;
                  end
                  state_in = ST_EMIT;
               end else begin
                  chan_in  = CH_SERVO;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               q_in     = den_zero_ff ? '0 : q_signed - q_offset;
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (chan_ff == CH_SERVO) begin
               servo_pos_in = q_servo;
            end
            if (chan_ff == CH_STRAIGHT) begin
               state_in = ST_MIX;
            end else begin
               chan_in  = chan_ff + 2'd1;
               state_in = ST_LOAD;
            end
         end
         ST_MIX: begin
            left_speed_in    = clamp_left;
            right_speed_in   = clamp_right;
            drive_enabled_in = enable_ff;
            link_timer_in    = '0;
            state_in         = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         chan_ff          <= CH_SERVO;
         link_timer_ff    <= '0;
         drive_enabled_ff <= 1'b0;
         left_speed_ff    <= '0;
         right_speed_ff   <= '0;
         servo_pos_ff     <= '0;
      end else begin
         state_ff         <= state_in;
         chan_ff          <= chan_in;
         link_timer_ff    <= link_timer_in;
         drive_enabled_ff <= drive_enabled_in;
         left_speed_ff    <= left_speed_in;
         right_speed_ff   <= right_speed_in;
         servo_pos_ff     <= servo_pos_in;
      end
   end

   // Packet fields, operand signs and mapped values carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept && (req_operation == OP_PACKET)) begin
         servo_stick_ff    <= req_servo_stick;
         turn_stick_ff     <= req_turn_stick;
         straight_stick_ff <= req_straight_stick;
         enable_ff         <= req_enable_switch;
      end
      if (state_ff == ST_LOAD) begin
         neg_ff      <= diff[SB] ^ den[SB];
         den_zero_ff <= (den == '0);
      end
      q_ff <= q_in;
      if ((state_ff == ST_POST) && (chan_ff == CH_TURN)) begin
         turn_ff <= q_dead;
      end
      if ((state_ff == ST_POST) && (chan_ff == CH_STRAIGHT)) begin
         straight_ff <= q_dead;
      end
   end

   // ---------------------------------------------------------------------
   // Output register. The result is built from the block state at the time
   // the item finishes; all drive legs and the servo read zero while the
   // drive is disabled.
   // ---------------------------------------------------------------------
   logic              emit_load;
   logic signed [8:0] left_neg;
   logic signed [8:0] right_neg;
   logic [7:0]        left_fwd_ff, left_rev_ff;
   logic [7:0]        right_fwd_ff, right_rev_ff;
   logic [7:0]        servo_deg_ff;
   logic              servo_on_ff;

   assign emit_load = (state_ff == ST_EMIT) && out_free;
   assign left_neg  = -left_speed_ff;
   assign right_neg = -right_speed_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         if (drive_enabled_ff) begin
            left_fwd_ff  <= left_speed_ff[8] ? 8'd0 : left_speed_ff[7:0];
            left_rev_ff  <= left_speed_ff[8] ? left_neg[7:0] : 8'd0;
            right_fwd_ff <= right_speed_ff[8] ? 8'd0 : right_speed_ff[7:0];
            right_rev_ff <= right_speed_ff[8] ? right_neg[7:0] : 8'd0;
            servo_deg_ff <= servo_pos_ff;
            servo_on_ff  <= 1'b1;
         end else begin
            left_fwd_ff  <= 8'd0;
            left_rev_ff  <= 8'd0;
            right_fwd_ff <= 8'd0;
            right_rev_ff <= 8'd0;
            servo_deg_ff <= 8'd0;
            servo_on_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_left_forward_pwm  = left_fwd_ff;
   assign rsp_left_reverse_pwm  = left_rev_ff;
   assign rsp_right_forward_pwm = right_fwd_ff;
   assign rsp_right_reverse_pwm = right_rev_ff;
   assign rsp_servo_deg         = servo_deg_ff;
   assign rsp_servo_active      = servo_on_ff;

endmodule

>>> rtl/ddm_divider.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
// No dependencies; used by the mixer top level for all stick mappings.
module ddm_divider #(
   parameter int NUM_BITS = 21,
   parameter int DEN_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic [DEN_BITS:0] partial;
   logic [DEN_BITS:0] trial;
   logic              fits;
   logic              busy;

   assign busy    = (cnt_ff != '0);
   assign partial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign trial   = partial - {1'b0, den_ff};
   assign fits    = (partial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = CNT_BITS'(NUM_BITS);
      end else if (busy) begin
         rem_in  = fits ? trial[DEN_BITS-1:0] : partial[DEN_BITS-1:0];
         quo_in  = {quo_ff[NUM_BITS-2:0], fits};
         cnt_in  = cnt_ff - CNT_BITS'(1);
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/ddm_checker.sv
// Port-level checker for the differential drive mixer, bound to its top level.
// Depends on ddm_pkg for the servo limit.
module ddm_sva_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_left_forward_pwm,
   input logic [7:0] rsp_left_reverse_pwm,
   input logic [7:0] rsp_right_forward_pwm,
   input logic [7:0] rsp_right_reverse_pwm,
   input logic [7:0] rsp_servo_deg,
   input logic       rsp_servo_active
);

   import ddm_pkg::*;

   // A disabled drive shows no duty on any leg and a parked servo.
   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_servo_active) |->
         (rsp_left_forward_pwm == 8'd0) && (rsp_left_reverse_pwm == 8'd0) &&
         (rsp_right_forward_pwm == 8'd0) && (rsp_right_reverse_pwm == 8'd0) &&
         (rsp_servo_deg == 8'd0))
      else $error("disabled result carries drive or servo value");

   // A motor is never driven forward and in reverse at once.
   a_one_leg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         !((rsp_left_forward_pwm != 8'd0) && (rsp_left_reverse_pwm != 8'd0)) &&
         !((rsp_right_forward_pwm != 8'd0) && (rsp_right_reverse_pwm != 8'd0)))
      else $error("both legs of one motor driven");

   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_servo_deg <= 8'(SERVO_MAX)))
      else $error("servo angle above limit");

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("new item taken while one is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         rsp_valid && $stable(rsp_left_forward_pwm) && $stable(rsp_left_reverse_pwm) &&
         $stable(rsp_right_forward_pwm) && $stable(rsp_right_reverse_pwm) &&
         $stable(rsp_servo_deg) && $stable(rsp_servo_active))
      else $error("stalled result changed");

endmodule

bind differential_drive_mixer_estop ddm_sva_checker u_ddm_sva_checker (.*);
